// ===== rtl/core/assert_macros.svh =====
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ctcgd_pkg.sv =====
//------------------------------------------------------------------------------
// ctcgd_pkg
// Shared constants and codes for the CTC greedy decoder.
//------------------------------------------------------------------------------
package ctcgd_pkg;

    localparam int MAX_CLASSES = 8192;
    localparam int MAX_STEPS   = 512;
    localparam int FIFO_DEPTH  = 4;

    localparam int LOGIT_W  = 16;
    localparam int CHAR_W   = 13;
    localparam int NC_W     = 14;
    localparam int MIN_W    = 15;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [NC_W-1:0]  NUM_CLASSES_RST = 14'd8192;
    localparam logic [MIN_W-1:0] MIN_SCORE_RST   = 15'd0;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE   = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MID_STEP = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

endpackage

// ===== rtl/core/ctcgd_fifo.sv =====
//------------------------------------------------------------------------------
// ctcgd_fifo
// Small event queue between the classifier front and the result back end.
//------------------------------------------------------------------------------
module ctcgd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ctcgd_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/ctcgd_front.sv =====
//------------------------------------------------------------------------------
// ctcgd_front
// Per-score argmax, step bookkeeping and character selection; posts events.
//------------------------------------------------------------------------------
module ctcgd_front #(
    parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES,
    parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS,
    parameter int CLS_W   = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1,
    parameter int STEP_W  = $clog2(MAX_STEPS + 1),
    parameter int TOTAL_W = ctcgd_pkg::LOGIT_W + STEP_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [ctcgd_pkg::LOGIT_W-1:0] i_logit,
    input  logic                                i_end_of_sequence,
    input  logic [ctcgd_pkg::NC_W-1:0]          i_num_classes,
    input  logic                                i_full,
    output logic                                o_push,
    output logic                                o_has_char,
    output logic [ctcgd_pkg::CHAR_W-1:0]        o_char_index,
    output logic                                o_has_sum,
    output logic signed [TOTAL_W-1:0]           o_total,
    output logic [STEP_W-1:0]                   o_count,
    output logic [ctcgd_pkg::STATUS_W-1:0]      o_status
);

    localparam int CMP_W = (CLS_W + 1 > ctcgd_pkg::NC_W) ? CLS_W + 1 : ctcgd_pkg::NC_W;

    logic [CLS_W-1:0]                     r_cls_cnt;
    logic signed [ctcgd_pkg::LOGIT_W-1:0] r_best_val;
    logic [CLS_W-1:0]                     r_best_cls;
    logic [CLS_W-1:0]                     r_prev_cls;
    logic                                 r_prev_vld;
    logic signed [TOTAL_W-1:0]            r_total;
    logic [STEP_W-1:0]                    r_sel_cnt;
    logic [STEP_W-1:0]                    r_step_cnt;
    logic                                 r_ovf;

    logic                                 accept;
    logic                                 take;
    logic signed [ctcgd_pkg::LOGIT_W-1:0] cur_val;
    logic [CLS_W-1:0]                     cur_cls;
    logic [CMP_W-1:0]                     nc_ext, nc_eff, cnt_p1;
    logic                                 complete;
    logic                                 step_ovf;
    logic                                 select;
    logic [CLS_W-1:0]                     idx_m1;
    logic signed [TOTAL_W-1:0]            total_nx;
    logic [STEP_W-1:0]                    sel_nx;
    logic                                 ovf_nx;

    assign accept = i_valid && !i_full;

    always_comb begin
        take    = (r_cls_cnt == '0) || (i_logit > r_best_val);
        cur_val = take ? i_logit : r_best_val;
        cur_cls = take ? r_cls_cnt : r_best_cls;

        nc_ext = CMP_W'(i_num_classes);
        if (nc_ext < CMP_W'(2)) begin
            nc_eff = CMP_W'(2);
        end else if (nc_ext > CMP_W'(MAX_CLASSES)) begin
            nc_eff = CMP_W'(MAX_CLASSES);
        end else begin
            nc_eff = nc_ext;
        end
        cnt_p1   = CMP_W'(r_cls_cnt) + 1'b1;
        complete = (cnt_p1 >= nc_eff);

        step_ovf = complete && (r_step_cnt >= STEP_W'(MAX_STEPS));
        select   = complete && !step_ovf && (cur_cls != '0)
                   && !(r_prev_vld && (cur_cls == r_prev_cls));
        idx_m1   = cur_cls - 1'b1;

        total_nx = select ? r_total + TOTAL_W'(cur_val) : r_total;
        sel_nx   = select ? r_sel_cnt + 1'b1 : r_sel_cnt;
        ovf_nx   = r_ovf || step_ovf;
    end

    assign o_push       = accept && (select || i_end_of_sequence);
    assign o_has_char   = select;
    assign o_char_index = ctcgd_pkg::CHAR_W'(idx_m1);
    assign o_has_sum    = i_end_of_sequence;
    assign o_total      = total_nx;
    assign o_count      = sel_nx;
    assign o_status     = ovf_nx ? ctcgd_pkg::STATUS_OVERFLOW :
                          (!complete ? ctcgd_pkg::STATUS_MID_STEP : ctcgd_pkg::STATUS_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_cnt  <= '0;
            r_best_val <= '0;
            r_best_cls <= '0;
            r_prev_cls <= '0;
            r_prev_vld <= 1'b0;
            r_total    <= '0;
            r_sel_cnt  <= '0;
            r_step_cnt <= '0;
            r_ovf      <= 1'b0;
        end else if (accept) begin
            if (i_end_of_sequence) begin
                r_cls_cnt  <= '0;
                r_best_val <= '0;
                r_best_cls <= '0;
                r_prev_cls <= '0;
                r_prev_vld <= 1'b0;
                r_total    <= '0;
                r_sel_cnt  <= '0;
                r_step_cnt <= '0;
                r_ovf      <= 1'b0;
            end else begin
                r_best_val <= cur_val;
                r_best_cls <= cur_cls;
                r_total    <= total_nx;
                r_sel_cnt  <= sel_nx;
                r_ovf      <= ovf_nx;
                if (complete) begin
                    r_cls_cnt <= '0;
                    if (!step_ovf) begin
                        r_step_cnt <= r_step_cnt + 1'b1;
                        r_prev_cls <= cur_cls;
                        r_prev_vld <= 1'b1;
                    end
                end else begin
                    r_cls_cnt <= r_cls_cnt + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/ctcgd_back.sv =====
//------------------------------------------------------------------------------
// ctcgd_back
// Drains events: sends characters, divides the score total for the summary.
//------------------------------------------------------------------------------
module ctcgd_back #(
    parameter int MAX_STEPS = ctcgd_pkg::MAX_STEPS,
    parameter int STEP_W    = $clog2(MAX_STEPS + 1),
    parameter int TOTAL_W   = ctcgd_pkg::LOGIT_W + STEP_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    input  logic                                 i_has_char,
    input  logic [ctcgd_pkg::CHAR_W-1:0]         i_char_index,
    input  logic                                 i_has_sum,
    input  logic signed [TOTAL_W-1:0]            i_total,
    input  logic [STEP_W-1:0]                    i_count,
    input  logic [ctcgd_pkg::STATUS_W-1:0]       i_status,
    input  logic [ctcgd_pkg::MIN_W-1:0]          i_min_score,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic                                 o_kind,
    output logic [ctcgd_pkg::CHAR_W-1:0]         o_char_index,
    output logic signed [ctcgd_pkg::LOGIT_W-1:0] o_avg_score,
    output logic                                 o_below_minimum,
    output logic [ctcgd_pkg::STATUS_W-1:0]       o_status,
    output logic                                 o_last
);

    localparam int DC_W = $clog2(TOTAL_W);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHAR = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_SUM  = 5'b10000
    } t_back_state;

    t_back_state                          r_state, n_state;
    logic                                 r_has_sum, n_has_sum;
    logic [STEP_W-1:0]                    r_count, n_count;
    logic [ctcgd_pkg::STATUS_W-1:0]       r_st, n_st;
    logic signed [TOTAL_W-1:0]            r_total, n_total;
    logic [TOTAL_W-1:0]                   r_quo, n_quo;
    logic [STEP_W-1:0]                    r_rem, n_rem;
    logic [DC_W-1:0]                      r_div_cnt, n_div_cnt;
    logic                                 r_neg, n_neg;

    logic                                 r_valid, n_valid;
    logic                                 r_kind, n_kind;
    logic [ctcgd_pkg::CHAR_W-1:0]         r_char, n_char;
    logic signed [ctcgd_pkg::LOGIT_W-1:0] r_avg, n_avg;
    logic                                 r_below, n_below;
    logic [ctcgd_pkg::STATUS_W-1:0]       r_ost, n_ost;
    logic                                 r_last, n_last;

    logic signed [TOTAL_W-1:0]            src_total;
    logic [TOTAL_W-1:0]                   mag;
    logic [STEP_W:0]                      rem_sh;
    logic                                 ge;
    logic [TOTAL_W-1:0]                   q_signed;
    logic signed [ctcgd_pkg::LOGIT_W-1:0] avg;

    always_comb begin
        src_total = (r_state == S_IDLE) ? i_total : r_total;
        mag       = src_total[TOTAL_W-1] ? TOTAL_W'(-src_total) : TOTAL_W'(src_total);
        rem_sh    = {r_rem, r_quo[TOTAL_W-1]};
        ge        = (rem_sh >= {1'b0, r_count});
        q_signed  = r_neg ? TOTAL_W'(-r_quo) : r_quo;
        avg       = (r_count == '0) ? '0 : q_signed[ctcgd_pkg::LOGIT_W-1:0];
    end

    always_comb begin
        n_state   = r_state;
        n_has_sum = r_has_sum;
        n_count   = r_count;
        n_st      = r_st;
        n_total   = r_total;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div_cnt = r_div_cnt;
        n_neg     = r_neg;
        n_valid   = r_valid;
        n_kind    = r_kind;
        n_char    = r_char;
        n_avg     = r_avg;
        n_below   = r_below;
        n_ost     = r_ost;
        n_last    = r_last;
        o_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_has_sum = i_has_sum;
                    n_count   = i_count;
                    n_st      = i_status;
                    n_total   = i_total;
                    n_quo     = mag;
                    n_rem     = '0;
                    n_div_cnt = '0;
                    n_neg     = i_total[TOTAL_W-1];
                    if (i_has_char) begin
                        n_valid = 1'b1;
                        n_kind  = ctcgd_pkg::KIND_CHAR;
                        n_char  = i_char_index;
                        n_avg   = '0;
                        n_below = 1'b0;
                        n_ost   = ctcgd_pkg::STATUS_OK;
                        n_last  = 1'b0;
                        n_state = S_CHAR;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_CHAR: begin
                if (!i_stall) begin
                    n_valid   = 1'b0;
                    n_quo     = mag;
                    n_rem     = '0;
                    n_div_cnt = '0;
                    n_neg     = r_total[TOTAL_W-1];
                    n_state   = r_has_sum ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                n_rem     = ge ? STEP_W'(rem_sh - {1'b0, r_count}) : STEP_W'(rem_sh);
                n_quo     = {r_quo[TOTAL_W-2:0], ge};
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DC_W'(TOTAL_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_valid = 1'b1;
                n_kind  = ctcgd_pkg::KIND_SUMMARY;
                n_char  = '0;
                n_avg   = avg;
                n_below = (avg < $signed({1'b0, i_min_score}));
                n_ost   = r_st;
                n_last  = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_valid = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_has_sum <= n_has_sum;
        r_count   <= n_count;
        r_st      <= n_st;
        r_total   <= n_total;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div_cnt <= n_div_cnt;
        r_neg     <= n_neg;
        r_kind    <= n_kind;
        r_char    <= n_char;
        r_avg     <= n_avg;
        r_below   <= n_below;
        r_ost     <= n_ost;
        r_last    <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_char_index    = r_char;
    assign o_avg_score     = r_avg;
    assign o_below_minimum = r_below;
    assign o_status        = r_ost;
    assign o_last          = r_last;

endmodule

// ===== rtl/core/ctc_greedy_decoder_core.sv =====
//------------------------------------------------------------------------------
// ctc_greedy_decoder_core
// Greedy best-path CTC decoder over a stream of Q8.8 class scores.
//------------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one class score per request, class 0 first,
// num_classes scores per time step; i_end_of_sequence marks the final score.
// The front takes one score per cycle while the event queue has room.
// Output channel (o_valid / i_stall): character requests (kind 0) as steps
// finish, then one summary request (kind 1, last 1) per sequence.
// The character chosen by the score that ends a step passes through the event
// queue and then the output register. A summary follows the end-of-sequence
// score once the one-bit-per-cycle restoring divider has formed the average.
// The back end pops the next event only after the current character is taken.
// When the receiver stalls the result is held in the output register; the
// 4-entry event queue absorbs the backlog, and o_stall rises once it is full.
// Configuration (i_cfg_valid / o_cfg_ready): always ready; index 0 is
// num_classes, index 1 is min_score; write only while the block is idle.
// Reset (synchronous, active low) clears the front's sequence state, the queue,
// the back end's state and output valid; it loads num_classes 8192, min_score 0.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module ctc_greedy_decoder_core #(
    parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES,
    parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [ctcgd_pkg::LOGIT_W-1:0]     i_logit,
    input  logic                                     i_end_of_sequence,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic                                     o_kind,
    output logic [ctcgd_pkg::CHAR_W-1:0]             o_char_index,
    output logic signed [ctcgd_pkg::LOGIT_W-1:0]     o_avg_score,
    output logic                                     o_below_minimum,
    output logic [ctcgd_pkg::STATUS_W-1:0]           o_status,
    output logic                                     o_last,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [ctcgd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ctcgd_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int CLS_W   = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int TOTAL_W = ctcgd_pkg::LOGIT_W + STEP_W;
    localparam int EV_W    = 1 + ctcgd_pkg::CHAR_W + 1 + TOTAL_W + STEP_W
                             + ctcgd_pkg::STATUS_W;

    logic [ctcgd_pkg::NC_W-1:0]     r_num_classes;
    logic [ctcgd_pkg::MIN_W-1:0]    r_min_score;

    logic                           push, full, empty, pop;
    logic                           f_has_char, f_has_sum;
    logic [ctcgd_pkg::CHAR_W-1:0]   f_char;
    logic signed [TOTAL_W-1:0]      f_total;
    logic [STEP_W-1:0]              f_count;
    logic [ctcgd_pkg::STATUS_W-1:0] f_status;
    logic                           b_has_char, b_has_sum;
    logic [ctcgd_pkg::CHAR_W-1:0]   b_char;
    logic signed [TOTAL_W-1:0]      b_total;
    logic [STEP_W-1:0]              b_count;
    logic [ctcgd_pkg::STATUS_W-1:0] b_status;
    logic [EV_W-1:0]                ev_in, ev_out;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= ctcgd_pkg::NUM_CLASSES_RST;
            r_min_score   <= ctcgd_pkg::MIN_SCORE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ctcgd_pkg::REG_NUM_CLASSES) begin
                r_num_classes <= i_cfg_data[ctcgd_pkg::NC_W-1:0];
            end else if (i_cfg_index == ctcgd_pkg::REG_MIN_SCORE) begin
                r_min_score <= i_cfg_data[ctcgd_pkg::MIN_W-1:0];
            end
        end
    end

    ctcgd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS),
        .CLS_W       (CLS_W),
        .STEP_W      (STEP_W),
        .TOTAL_W     (TOTAL_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_logit           (i_logit),
        .i_end_of_sequence (i_end_of_sequence),
        .i_num_classes     (r_num_classes),
        .i_full            (full),
        .o_push            (push),
        .o_has_char        (f_has_char),
        .o_char_index      (f_char),
        .o_has_sum         (f_has_sum),
        .o_total           (f_total),
        .o_count           (f_count),
        .o_status          (f_status)
    );

    assign ev_in = {f_has_char, f_char, f_has_sum, f_total, f_count, f_status};
    assign {b_has_char, b_char, b_has_sum, b_total, b_count, b_status} = ev_out;

    ctcgd_fifo #(
        .WIDTH (EV_W),
        .DEPTH (ctcgd_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (ev_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (ev_out),
        .o_empty (empty)
    );

    ctcgd_back #(
        .MAX_STEPS (MAX_STEPS),
        .STEP_W    (STEP_W),
        .TOTAL_W   (TOTAL_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .o_pop           (pop),
        .i_has_char      (b_has_char),
        .i_char_index    (b_char),
        .i_has_sum       (b_has_sum),
        .i_total         (b_total),
        .i_count         (b_count),
        .i_status        (b_status),
        .i_min_score     (r_min_score),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_char_index    (o_char_index),
        .o_avg_score     (o_avg_score),
        .o_below_minimum (o_below_minimum),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    `ASSERT_IMPLIES(a_push_has_room, i_clk, i_rst_n, push, !full && i_valid)
    `ASSERT_IMPLIES(a_pop_not_empty, i_clk, i_rst_n, pop, !empty)
    `ASSERT_IMPLIES(a_status_code, i_clk, i_rst_n, o_valid, o_status <= ctcgd_pkg::STATUS_OVERFLOW)
    `ASSERT_NEXT(a_summary_reloads, i_clk, i_rst_n, o_valid && o_last && !i_stall, !o_valid)

endmodule

// ===== sim/ctc_greedy_decoder_core_tb.sv =====
//------------------------------------------------------------------------------
// ctc_greedy_decoder_core_tb
// Self-checking testbench for the greedy CTC decoder core.
// Streams Q8.8 class scores through the valid/stall input channel and predicts
// every character and summary request with a behavioral decoder. Each output
// request is compared field by field with that prediction. Coverage includes
// directed argmax, repeat, blank and mid-step cases, randomized sequences
// under several register settings, a long receiver hold-off, step overflow
// and a class count above the limit.
//------------------------------------------------------------------------------
module ctc_greedy_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOGIT_W     = ctcgd_pkg::LOGIT_W;
    localparam int CHAR_W      = ctcgd_pkg::CHAR_W;
    localparam int NC_W        = ctcgd_pkg::NC_W;
    localparam int MIN_W       = ctcgd_pkg::MIN_W;
    localparam int STATUS_W    = ctcgd_pkg::STATUS_W;
    localparam int CFG_IDX_W   = ctcgd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = ctcgd_pkg::CFG_DATA_W;
    localparam int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES;
    localparam int MAX_STEPS   = ctcgd_pkg::MAX_STEPS;

    localparam int DRAIN_CYCLES = 40;
    localparam int NO_WINNER    = -1;
    localparam int WIDE_SCORES  = 24;
    localparam int RANDOM_ITEMS = 80;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic                       kind;
        logic [CHAR_W-1:0]          char_index;
        logic signed [LOGIT_W-1:0]  avg_score;
        logic                       below_minimum;
        logic [STATUS_W-1:0]        status;
        logic                       last;
    } t_ctc_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [LOGIT_W-1:0]     i_logit = '0;
    logic                          i_end_of_sequence = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_kind;
    logic [CHAR_W-1:0]             o_char_index;
    logic signed [LOGIT_W-1:0]     o_avg_score;
    logic                          o_below_minimum;
    logic [STATUS_W-1:0]           o_status;
    logic                          o_last;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    // decoder state mirror
    logic [NC_W-1:0]   cfg_num_classes;
    logic [MIN_W-1:0]  cfg_min_score;
    int                class_pos;
    int                best_score;
    int                best_pos;
    int                prev_winner;
    longint            picked_total;
    int                picked_count;
    int                steps_done;
    bit                steps_overflowed;

    t_ctc_result       outputs_due[$];
    t_ctc_result       head;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_hold_left = 0;
    int last_target = 0;

    int mismatches = 0;
    int scores_sent = 0;
    int sequences_done = 0;
    int cfg_writes = 0;
    int chars_checked = 0;
    int summaries_checked = 0;

    ctc_greedy_decoder_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_logit           (i_logit),
        .i_end_of_sequence (i_end_of_sequence),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_char_index      (o_char_index),
        .o_avg_score       (o_avg_score),
        .o_below_minimum   (o_below_minimum),
        .o_status          (o_status),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    //--------------------------------------------------------------------------
    // Prediction
    //--------------------------------------------------------------------------
    task automatic clear_sequence_state();
        class_pos        = 0;
        best_score       = 0;
        best_pos         = 0;
        prev_winner      = NO_WINNER;
        picked_total     = 0;
        picked_count     = 0;
        steps_done       = 0;
        steps_overflowed = 1'b0;
    endtask

    function automatic int effective_classes();
        int n;
        n = cfg_num_classes;
        if (n < 2) n = 2;
        if (n > MAX_CLASSES) n = MAX_CLASSES;
        return n;
    endfunction

    function automatic t_ctc_result make_result(logic kind, int ch, int avg, logic below,
                                                logic [STATUS_W-1:0] status, logic last);
        t_ctc_result r;
        r.kind          = kind;
        r.char_index    = ch[CHAR_W-1:0];
        r.avg_score     = avg[LOGIT_W-1:0];
        r.below_minimum = below;
        r.status        = status;
        r.last          = last;
        return r;
    endfunction

    task automatic queue_result(input t_ctc_result r);
        outputs_due.insert(outputs_due.size(), r);
    endtask

    task automatic decode_score(input logic signed [LOGIT_W-1:0] score, input bit eos);
        int                  nc;
        bit                  step_done;
        int                  mean;
        logic [STATUS_W-1:0] status;
        nc = effective_classes();
        if (class_pos == 0 || score > best_score) begin
            best_score = score;
            best_pos   = class_pos;
        end
        step_done = (class_pos + 1 >= nc);
        if (step_done) begin
            if (steps_done >= MAX_STEPS) begin
                steps_overflowed = 1'b1;
            end else begin
                steps_done++;
                if (best_pos != 0 && best_pos != prev_winner) begin
                    queue_result(make_result(ctcgd_pkg::KIND_CHAR, best_pos - 1, 0, 1'b0,
                                             ctcgd_pkg::STATUS_OK, 1'b0));
                    picked_total += best_score;
                    picked_count++;
                end
                prev_winner = best_pos;
            end
            class_pos = 0;
        end else begin
            class_pos++;
        end
        if (eos) begin
            mean = 0;
            if (picked_count > 0) mean = int'(picked_total / longint'(picked_count));
            if (steps_overflowed) status = ctcgd_pkg::STATUS_OVERFLOW;
            else if (!step_done) status = ctcgd_pkg::STATUS_MID_STEP;
            else status = ctcgd_pkg::STATUS_OK;
            queue_result(make_result(ctcgd_pkg::KIND_SUMMARY, 0, mean,
                                     mean < int'(cfg_min_score), status, 1'b1));
            sequences_done++;
            clear_sequence_state();
        end
    endtask

    //--------------------------------------------------------------------------
    // Checking
    //--------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t request %0d: %s", $time,
                 chars_checked + summaries_checked, msg);
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (outputs_due.size() == 0) begin
                report_mismatch($sformatf("unexpected request, kind %0d char %0d",
                                          o_kind, o_char_index));
            end else begin
                head = outputs_due.pop_front();
                compare_field("kind", o_kind, head.kind);
                compare_field("char_index", o_char_index, head.char_index);
                compare_field("avg_score", o_avg_score, head.avg_score);
                compare_field("below_minimum", o_below_minimum, head.below_minimum);
                compare_field("status", o_status, head.status);
                compare_field("last", o_last, head.last);
                if (head.kind == ctcgd_pkg::KIND_SUMMARY) summaries_checked++;
                else chars_checked++;
            end
        end
    end

    // receiver: random stall, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (stall_hold_left > 0) begin
            stall_hold_left = stall_hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    //--------------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------------
    task automatic send_score(input logic signed [LOGIT_W-1:0] score, input bit eos);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_logit           <= score;
        i_end_of_sequence <= eos;
        do @(posedge i_clk); while (o_stall);
        scores_sent++;
        decode_score(score, eos);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == ctcgd_pkg::REG_NUM_CLASSES) cfg_num_classes = data[NC_W-1:0];
        else if (index == ctcgd_pkg::REG_MIN_SCORE) cfg_min_score = data[MIN_W-1:0];
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic logic signed [LOGIT_W-1:0] random_logit();
        return LOGIT_W'($urandom);
    endfunction

    // one full time step; the winner is steered so repeats and blanks are common
    task automatic send_step(input int nc, input bit eos_at_end);
        int                        shape;
        int                        target;
        int                        c;
        logic signed [LOGIT_W-1:0] v;
        shape  = $urandom_range(0, 9);
        target = (shape < 3 && last_target < nc) ? last_target : $urandom_range(0, nc - 1);
        last_target = target;
        for (c = 0; c < nc; c++) begin
            if (shape >= 8) v = random_logit();
            else if (shape >= 6) v = LOGIT_W'($urandom_range(0, 2) - 1);
            else if (c == target) v = LOGIT_W'($urandom_range(1000, 32767));
            else v = LOGIT_W'($urandom_range(0, 1999) - 1000);
            send_score(v, eos_at_end && c == nc - 1);
        end
    endtask

    // partial > 0 ends the sequence that many scores into an unfinished step
    task automatic send_sequence(input int steps, input int partial);
        int nc;
        int s;
        int p;
        nc = effective_classes();
        for (s = 0; s < steps; s++) send_step(nc, partial == 0 && s == steps - 1);
        for (p = 0; p < partial; p++) send_score(random_logit(), p == partial - 1);
    endtask

    task automatic write_random_config();
        int                    pick;
        logic [CFG_DATA_W-1:0] nc_data;
        logic [CFG_DATA_W-1:0] min_data;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            nc_data = CFG_DATA_W'($urandom_range(0, 1)) | CFG_DATA_W'($urandom_range(0, 3) << 14);
        else if (pick < 3)
            nc_data = CFG_DATA_W'($urandom_range(13, 40));
        else
            nc_data = CFG_DATA_W'($urandom_range(2, 12));
        pick = $urandom_range(0, 9);
        if (pick == 0) min_data = '0;
        else if (pick < 5) min_data = CFG_DATA_W'($urandom_range(0, 65535));
        else min_data = CFG_DATA_W'($urandom_range(0, 3000));
        write_reg(ctcgd_pkg::REG_NUM_CLASSES, nc_data);
        write_reg(ctcgd_pkg::REG_MIN_SCORE, min_data);
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------
    task automatic test_first_max_and_repeats();
        wait_idle();
        write_reg(REG_SPARE_2, 16'h5A5A);
        write_reg(REG_SPARE_3, 16'hA5A5);
        write_reg(ctcgd_pkg::REG_NUM_CLASSES, 16'd3);
        write_reg(ctcgd_pkg::REG_MIN_SCORE, 16'h0100);
        // tie at the maximum: the lower class index wins
        send_score(-32768, 1'b0); send_score(32767, 1'b0); send_score(32767, 1'b0);
        // blank step
        send_score(0, 1'b0); send_score(0, 1'b0); send_score(0, 1'b0);
        // same character after a blank is emitted again
        send_score(0, 1'b0); send_score(5, 1'b0); send_score(0, 1'b0);
        // direct repeat is suppressed; sequence ends on a step boundary
        send_score(0, 1'b0); send_score(6, 1'b0); send_score(0, 1'b1);
    endtask

    task automatic test_negative_mean_mid_step();
        wait_idle();
        write_reg(ctcgd_pkg::REG_NUM_CLASSES, 16'hC000);   // masks to zero, behaves as 2
        write_reg(ctcgd_pkg::REG_MIN_SCORE, 16'hFFFF);     // masks to the top threshold
        send_score(-32768, 1'b0); send_score(-1, 1'b0);
        send_score(0, 1'b0);      send_score(-2, 1'b0);
        send_score(-32768, 1'b0); send_score(-2, 1'b0);
        send_score(-5, 1'b1);
    endtask

    task automatic test_empty_sequences();
        wait_idle();
        write_reg(ctcgd_pkg::REG_MIN_SCORE, 16'h8000);
        send_score(7, 1'b1);
        send_score(3, 1'b0); send_score(1, 1'b1);
    endtask

    task automatic test_random_traffic(input int n_items);
        int start_count;
        int steps;
        int partial;
        int nc;
        start_count = scores_sent;
        while (scores_sent - start_count < n_items) begin
            wait_idle();
            write_random_config();
            nc = effective_classes();
            repeat ($urandom_range(1, 3)) begin
                steps   = $urandom_range(0, 4);
                partial = (steps == 0 || $urandom_range(0, 9) == 0) ?
                          $urandom_range(1, nc - 1) : 0;
                send_sequence(steps, partial);
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(ctcgd_pkg::REG_NUM_CLASSES, 16'd3);
        stall_hold_left = 400;
        send_sequence(30, 0);
        wait_idle();
    endtask

    // one step more than the limit, then a cut-off step: both faults at once
    task automatic test_step_overflow();
        wait_idle();
        write_reg(ctcgd_pkg::REG_NUM_CLASSES, 16'h4000);
        write_reg(ctcgd_pkg::REG_MIN_SCORE, CFG_DATA_W'($urandom_range(0, 65535)));
        send_sequence(MAX_STEPS + 1, 1);
        wait_idle();
    endtask

    // a class count above the limit clamps, so a short sequence ends mid-step
    task automatic test_wide_class_count();
        int c;
        wait_idle();
        write_reg(ctcgd_pkg::REG_NUM_CLASSES, 16'hFFFF);
        write_reg(ctcgd_pkg::REG_MIN_SCORE, 16'd0);
        for (c = 0; c < WIDE_SCORES; c++) begin
            send_score(random_logit(), c == WIDE_SCORES - 1);
        end
        wait_idle();
    endtask

    //--------------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------------
    initial begin
        cfg_num_classes = ctcgd_pkg::NUM_CLASSES_RST;
        cfg_min_score   = ctcgd_pkg::MIN_SCORE_RST;
        clear_sequence_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idle(15, 61);
        test_first_max_and_repeats();
        test_negative_mean_mid_step();
        test_empty_sequences();
        test_random_traffic(RANDOM_ITEMS);

        set_idle(61, 15);
        test_step_overflow();
        test_random_traffic(RANDOM_ITEMS);
        test_backpressure();

        set_idle(0, 0);
        test_wide_class_count();
        test_random_traffic(RANDOM_ITEMS);

        wait_idle();
        $display("Ran %0d class scores in %0d sequences with %0d register writes.",
                 scores_sent, sequences_done, cfg_writes);
        $display("Checked %0d character requests and %0d summaries.",
                 chars_checked, summaries_checked);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d requests still expected", outputs_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
